// File: sv/i2cee_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the I2C EEPROM image server.
// Used by i2cee_image_ram, i2cee_bus_fsm and i2c_slave_eeprom_image_server.
package i2cee_pkg;

    localparam int IDX_W       = 9;
    localparam int IMAGE_DEPTH = 1 << IDX_W;
    localparam int BYTE_W      = 8;
    localparam int BIT_CNT_W   = 4;
    localparam int BYTE_CNT_W  = 3;

    typedef enum logic
    {
        OP_LINE_SAMPLE = 1'b0,
        OP_LOAD_BYTE   = 1'b1
    } opcode_t;

    typedef enum logic [1:0]
    {
        ST_NONE      = 2'd0,
        ST_NACK_END  = 2'd1,
        ST_BAD_START = 2'd2
    } status_t;

    typedef enum logic [3:0]
    {
        PH_WAIT_IDLE   = 4'd0,
        PH_ARMED       = 4'd1,
        PH_RX          = 4'd2,
        PH_ACK_SET     = 4'd3,
        PH_ACK_HOLD    = 4'd4,
        PH_RE_IDLE     = 4'd5,
        PH_RE_START    = 4'd6,
        PH_TX          = 4'd7,
        PH_MACK_SAMPLE = 4'd8,
        PH_MACK_ACKED  = 4'd9,
        PH_MACK_NACKED = 4'd10
    } phase_t;

    typedef struct packed
    {
        logic             drive_low;
        status_t          status;
        logic [IDX_W-1:0] read_index;
    } resp_t;

endpackage

// File: sv/i2cee_image_ram.sv
`timescale 1ns / 1ps
// Image byte store: one write port, one read port, registered read data.
// Forwards write data on a same-address read. Depends on i2cee_pkg.
module i2cee_image_ram
    import i2cee_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [IDX_W-1:0]  waddr,
    input  logic [BYTE_W-1:0] wdata,
    input  logic [IDX_W-1:0]  raddr,
    output logic [BYTE_W-1:0] rdata
);

    logic [BYTE_W-1:0] mem [IMAGE_DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/i2cee_bus_fsm.sv
`timescale 1ns / 1ps
// Bus sequencer: start detection, byte receive and ack, image byte transmit.
// Takes prefetched image data from i2cee_image_ram. Depends on i2cee_pkg.
module i2cee_bus_fsm
    import i2cee_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              scl,
    input  logic              sda,
    input  logic [BYTE_W-1:0] image_byte,
    output logic [IDX_W-1:0]  read_index,
    output resp_t             result
);

    phase_t                phase_reg,      phase_next;
    logic [BIT_CNT_W-1:0]  bit_cnt_reg,    bit_cnt_next;
    logic [BYTE_CNT_W-1:0] byte_cnt_reg,   byte_cnt_next;
    logic [BYTE_W-1:0]     shift_reg,      shift_next;
    logic [IDX_W-1:0]      read_index_reg, read_index_next;
    logic                  last_scl_reg,   last_scl_next;
    logic                  drive_low_reg,  drive_low_next;
    status_t               status_next;

    logic                  rise;
    logic                  fall;
    logic                  idle;
    logic [BYTE_CNT_W-1:0] byte_cnt_inc;

    assign rise         = !last_scl_reg && scl;
    assign fall         = last_scl_reg && !scl;
    assign idle         = scl && sda;
    assign byte_cnt_inc = byte_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_WAIT_IDLE;
            bit_cnt_reg    <= '0;
            byte_cnt_reg   <= '0;
            shift_reg      <= '0;
            read_index_reg <= '0;
            last_scl_reg   <= 1'b1;
            drive_low_reg  <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            bit_cnt_reg    <= bit_cnt_next;
            byte_cnt_reg   <= byte_cnt_next;
            shift_reg      <= shift_next;
            read_index_reg <= read_index_next;
            last_scl_reg   <= last_scl_next;
            drive_low_reg  <= drive_low_next;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        bit_cnt_next    = bit_cnt_reg;
        byte_cnt_next   = byte_cnt_reg;
        shift_next      = shift_reg;
        read_index_next = read_index_reg;
        last_scl_next   = last_scl_reg;
        drive_low_next  = drive_low_reg;
        status_next     = ST_NONE;

        if (step)
        begin
            last_scl_next = scl;
            case (phase_reg)
                PH_ARMED:
                begin
                    if (!idle)
                    begin
                        if (scl && !sda)
                        begin
                            phase_next      = PH_RX;
                            bit_cnt_next    = '0;
                            byte_cnt_next   = '0;
                            shift_next      = '0;
                            read_index_next = '0;
                        end
                        else
                        begin
                            status_next = ST_BAD_START;
                            phase_next  = PH_WAIT_IDLE;
                        end
                    end
                end
                PH_RX:
                begin
                    if (rise)
                    begin
                        shift_next   = {shift_reg[BYTE_W-2:0], sda};
                        bit_cnt_next = bit_cnt_reg + 1'b1;
                        if (bit_cnt_next >= BIT_CNT_W'(BYTE_W))
                        begin
                            phase_next = PH_ACK_SET;
                        end
                    end
                end
                PH_ACK_SET:
                begin
                    if (fall)
                    begin
                        drive_low_next = 1'b1;
                        phase_next     = PH_ACK_HOLD;
                    end
                end
                PH_ACK_HOLD:
                begin
                    if (fall)
                    begin
                        drive_low_next = 1'b0;
                        byte_cnt_next  = byte_cnt_inc;
                        if (byte_cnt_inc == BYTE_CNT_W'(3))
                        begin
                            phase_next = PH_RE_IDLE;
                        end
                        else if (byte_cnt_inc >= BYTE_CNT_W'(4))
                        begin
                            drive_low_next = !image_byte[BYTE_W-1];
                            shift_next     = {image_byte[BYTE_W-2:0], 1'b0};
                            bit_cnt_next   = BIT_CNT_W'(1);
                            phase_next     = PH_TX;
                        end
                        else
                        begin
                            phase_next   = PH_RX;
                            bit_cnt_next = '0;
                            shift_next   = '0;
                        end
                    end
                end
                PH_RE_IDLE:
                begin
                    if (idle)
                    begin
                        phase_next = PH_RE_START;
                    end
                end
                PH_RE_START:
                begin
                    if (!idle)
                    begin
                        phase_next   = PH_RX;
                        bit_cnt_next = '0;
                        shift_next   = '0;
                    end
                end
                PH_TX:
                begin
                    if (fall)
                    begin
                        if (bit_cnt_reg < BIT_CNT_W'(BYTE_W))
                        begin
                            drive_low_next = !shift_reg[BYTE_W-1];
                            shift_next     = {shift_reg[BYTE_W-2:0], 1'b0};
                            bit_cnt_next   = bit_cnt_reg + 1'b1;
                        end
                        else
                        begin
                            drive_low_next  = 1'b0;
                            read_index_next = read_index_reg + 1'b1;
                            phase_next      = PH_MACK_SAMPLE;
                        end
                    end
                end
                PH_MACK_SAMPLE:
                begin
                    if (rise)
                    begin
                        phase_next = sda ? PH_MACK_NACKED : PH_MACK_ACKED;
                    end
                end
                PH_MACK_ACKED:
                begin
                    if (fall)
                    begin
                        drive_low_next = !image_byte[BYTE_W-1];
                        shift_next     = {image_byte[BYTE_W-2:0], 1'b0};
                        bit_cnt_next   = BIT_CNT_W'(1);
                        phase_next     = PH_TX;
                    end
                end
                PH_MACK_NACKED:
                begin
                    if (fall)
                    begin
                        status_next    = ST_NACK_END;
                        drive_low_next = 1'b0;
                        phase_next     = PH_WAIT_IDLE;
                    end
                end
                default:
                begin
                    phase_next = idle ? PH_ARMED : PH_WAIT_IDLE;
                end
            endcase
        end
    end

    assign read_index        = read_index_reg;
    assign result.drive_low  = drive_low_next;
    assign result.status     = status_next;
    assign result.read_index = read_index_next;

endmodule

// File: sv/i2c_slave_eeprom_image_server.sv
`timescale 1ns / 1ps
// I2C EEPROM image server top level. The result is registered and valid in the cycle after the input transfer.
// Throughput: one item per cycle; the input stalls only while the result register is
// full and the output is stalled. The image RAM is read every cycle at the current read
// index, so the next byte is ready when the master acks.
// Reset: bus sequencer waits for idle, counters clear, its SDA drive clears; result register and image not cleared.
module i2c_slave_eeprom_image_server
    import i2cee_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              opcode,
    input  logic              scl_level,
    input  logic              sda_level,
    input  logic [IDX_W-1:0]  load_index,
    input  logic [BYTE_W-1:0] load_byte,
    output logic              out_valid,
    input  logic              out_stall,
    output logic              sda_pull_low,
    output logic [1:0]        status,
    output logic [IDX_W-1:0]  bytes_sent
);

    logic              accept;
    logic              step;
    logic              load_we;
    logic [BYTE_W-1:0] image_byte;
    logic [IDX_W-1:0]  read_index;
    resp_t             result;

    logic              out_valid_reg, out_valid_next;
    resp_t             result_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign step     = accept && (opcode == OP_LINE_SAMPLE);
    assign load_we  = accept && (opcode == OP_LOAD_BYTE);

    i2cee_image_ram u_ram
    (
        .clk   (clk),
        .we    (load_we),
        .waddr (load_index),
        .wdata (load_byte),
        .raddr (read_index),
        .rdata (image_byte)
    );

    i2cee_bus_fsm u_fsm
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .scl        (scl_level),
        .sda        (sda_level),
        .image_byte (image_byte),
        .read_index (read_index),
        .result     (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign sda_pull_low = result_reg.drive_low;
    assign status       = result_reg.status;
    assign bytes_sent   = result_reg.read_index;

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted item produced no result");

    a_load_status_none: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (opcode == OP_LOAD_BYTE) |=> status == ST_NONE)
        else $error("load item reported a bus status");

    a_nack_releases_sda: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NACK_END) |-> !sda_pull_low)
        else $error("SDA still driven at end of transfer");

    a_bad_start_released: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_BAD_START) |-> !sda_pull_low)
        else $error("SDA driven on bad start");

endmodule

// File: verif/tb_i2c_slave_eeprom_image_server.sv
`timescale 1ns / 1ps
// Self-checking testbench for i2c_slave_eeprom_image_server: drives SCL/SDA samples and image
// loads, mirrors the slave's bus sequencer in place and checks every result transfer.
// Depends on i2cee_pkg and the i2c_slave_eeprom_image_server RTL only.
module tb_i2c_slave_eeprom_image_server;
    import i2cee_pkg::*;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              in_valid     = 1'b0;
    logic              in_stall;
    logic              opcode       = OP_LINE_SAMPLE;
    logic              scl_level    = 1'b1;
    logic              sda_level    = 1'b1;
    logic [IDX_W-1:0]  load_index   = '0;
    logic [BYTE_W-1:0] load_byte    = '0;
    logic              out_valid;
    logic              out_stall    = 1'b0;
    logic              sda_pull_low;
    logic [1:0]        status;
    logic [IDX_W-1:0]  bytes_sent;

    phase_t                 bus_phase   = PH_WAIT_IDLE;
    logic [BIT_CNT_W-1:0]   rx_bits     = '0;
    logic [BYTE_CNT_W-1:0]  byte_count  = '0;
    logic [BYTE_W-1:0]      shift_byte  = '0;
    logic [IDX_W-1:0]       tx_index    = '0;
    logic                   scl_prev    = 1'b1;
    logic                   bus_pull    = 1'b0;
    logic [BYTE_W-1:0]      image_mirror [IMAGE_DEPTH];

    resp_t   pending_responses [$];
    int      mismatches        = 0;
    int      items_sent        = 0;
    int      responses_checked = 0;
    int      nack_ends         = 0;
    int      bad_starts        = 0;
    int      cut_left          = -1;
    bit      no_idle           = 1'b0;

    i2c_slave_eeprom_image_server u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .scl_level    (scl_level),
        .sda_level    (sda_level),
        .load_index   (load_index),
        .load_byte    (load_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sda_pull_low (sda_pull_low),
        .status       (status),
        .bytes_sent   (bytes_sent)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= !no_idle && ($urandom_range(99) < 30);
    end

    task automatic shift_out_bit();
        bus_pull   = ~shift_byte[BYTE_W-1];
        shift_byte = shift_byte << 1;
        rx_bits    = rx_bits + 1'b1;
    endtask

    task automatic load_tx_byte();
        shift_byte = image_mirror[tx_index];
        rx_bits    = '0;
        shift_out_bit();
        bus_phase  = PH_TX;
    endtask

    task automatic predict_bus_response(input opcode_t op, input logic scl, input logic sda,
                                        input logic [IDX_W-1:0] idx,
                                        input logic [BYTE_W-1:0] data);
        status_t st;
        logic    rise;
        logic    fall;
        logic    idle;
        resp_t   r;
        st = ST_NONE;
        if (op == OP_LOAD_BYTE)
        begin
            image_mirror[idx] = data;
        end
        else
        begin
            rise = !scl_prev && scl;
            fall = scl_prev && !scl;
            idle = scl && sda;
            case (bus_phase)
                PH_ARMED:
                begin
                    if (!idle)
                    begin
                        if (scl && !sda)
                        begin
                            bus_phase  = PH_RX;
                            rx_bits    = '0;
                            byte_count = '0;
                            shift_byte = '0;
                            tx_index   = '0;
                        end
                        else
                        begin
                            st        = ST_BAD_START;
                            bus_phase = PH_WAIT_IDLE;
                        end
                    end
                end
                PH_RX:
                begin
                    if (rise)
                    begin
                        shift_byte = {shift_byte[BYTE_W-2:0], sda};
                        rx_bits    = rx_bits + 1'b1;
                        if (rx_bits >= 8)
                            bus_phase = PH_ACK_SET;
                    end
                end
                PH_ACK_SET:
                begin
                    if (fall)
                    begin
                        bus_pull  = 1'b1;
                        bus_phase = PH_ACK_HOLD;
                    end
                end
                PH_ACK_HOLD:
                begin
                    if (fall)
                    begin
                        bus_pull   = 1'b0;
                        byte_count = byte_count + 1'b1;
                        if (byte_count == 3)
                            bus_phase = PH_RE_IDLE;
                        else if (byte_count >= 4)
                            load_tx_byte();
                        else
                        begin
                            bus_phase  = PH_RX;
                            rx_bits    = '0;
                            shift_byte = '0;
                        end
                    end
                end
                PH_RE_IDLE:
                begin
                    if (idle)
                        bus_phase = PH_RE_START;
                end
                PH_RE_START:
                begin
                    if (!idle)
                    begin
                        bus_phase  = PH_RX;
                        rx_bits    = '0;
                        shift_byte = '0;
                    end
                end
                PH_TX:
                begin
                    if (fall)
                    begin
                        if (rx_bits < 8)
                            shift_out_bit();
                        else
                        begin
                            bus_pull  = 1'b0;
                            tx_index  = tx_index + 1'b1;
                            bus_phase = PH_MACK_SAMPLE;
                        end
                    end
                end
                PH_MACK_SAMPLE:
                begin
                    if (rise)
                        bus_phase = sda ? PH_MACK_NACKED : PH_MACK_ACKED;
                end
                PH_MACK_ACKED:
                begin
                    if (fall)
                        load_tx_byte();
                end
                PH_MACK_NACKED:
                begin
                    if (fall)
                    begin
                        st        = ST_NACK_END;
                        bus_pull  = 1'b0;
                        bus_phase = PH_WAIT_IDLE;
                    end
                end
                default:
                begin
                    bus_phase = idle ? PH_ARMED : PH_WAIT_IDLE;
                end
            endcase
            scl_prev = scl;
        end
        if (st == ST_NACK_END)
            nack_ends++;
        if (st == ST_BAD_START)
            bad_starts++;
        r.drive_low  = bus_pull;
        r.status     = st;
        r.read_index = tx_index;
        pending_responses.push_back(r);
    endtask

    task automatic send_item(input opcode_t op, input logic scl, input logic sda,
                             input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        if (!no_idle && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        scl_level  <= scl;
        sda_level  <= sda;
        load_index <= idx;
        load_byte  <= data;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        predict_bus_response(op, scl, sda, idx, data);
    endtask

    // Line level is the wired AND of the master and the slave's expected pull-down.
    task automatic bus(input logic scl, input logic m_sda);
        if (cut_left == 0)
            return;
        if (cut_left > 0)
            cut_left--;
        if ($urandom_range(99) < 4)
            send_item(OP_LOAD_BYTE, 1'($urandom_range(1)), 1'($urandom_range(1)),
                      IDX_W'($urandom_range(IMAGE_DEPTH - 1)), BYTE_W'($urandom_range(255)));
        send_item(OP_LINE_SAMPLE, scl, m_sda & ~bus_pull,
                  IDX_W'($urandom_range(IMAGE_DEPTH - 1)), BYTE_W'($urandom_range(255)));
        if ($urandom_range(99) < 15)
            send_item(OP_LINE_SAMPLE, scl, m_sda & ~bus_pull,
                      IDX_W'($urandom_range(IMAGE_DEPTH - 1)), BYTE_W'($urandom_range(255)));
    endtask

    task automatic master_byte(input logic [BYTE_W-1:0] b);
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            bus(1'b0, b[i]);
            bus(1'b1, b[i]);
        end
        bus(1'b0, 1'b1);
        bus(1'b1, 1'b1);
    endtask

    task automatic run_transfer(input int n_read);
        repeat ($urandom_range(1, 2)) bus(1'b1, 1'b1);
        bus(1'b1, 1'b0);
        repeat (3) master_byte(BYTE_W'($urandom_range(255)));
        bus(1'b0, 1'b1);
        bus(1'b1, 1'b1);
        bus(1'b1, 1'b0);
        master_byte(BYTE_W'($urandom_range(255)));
        bus(1'b0, 1'b1);
        for (int k = 0; k < n_read; k++)
        begin
            repeat (8)
            begin
                bus(1'b1, 1'b1);
                bus(1'b0, 1'b1);
            end
            bus(1'b1, k == n_read - 1);
            bus(1'b0, k == n_read - 1);
        end
        bus(1'b0, 1'b0);
        bus(1'b1, 1'b0);
        bus(1'b1, 1'b1);
    endtask

    task automatic noise_burst();
        repeat ($urandom_range(4, 30))
            send_item(($urandom_range(9) == 0) ? OP_LOAD_BYTE : OP_LINE_SAMPLE,
                      1'($urandom_range(1)), 1'($urandom_range(1)),
                      IDX_W'($urandom_range(IMAGE_DEPTH - 1)), BYTE_W'($urandom_range(255)));
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        while (pending_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_load_extremes();
        send_item(OP_LOAD_BYTE, 1'b0, 1'b0, IDX_W'(IMAGE_DEPTH - 1), 8'hFF);
        send_item(OP_LOAD_BYTE, 1'b1, 1'b1, IDX_W'(0), 8'h00);
        send_item(OP_LOAD_BYTE, 1'b0, 1'b1, IDX_W'(1), 8'hFF);
        send_item(OP_LOAD_BYTE, 1'b1, 1'b0, IDX_W'(0), 8'h5A);
        send_item(OP_LOAD_BYTE, 1'b0, 1'b0, IDX_W'(IMAGE_DEPTH / 2), 8'h01);
    endtask

    task automatic test_bad_start();
        bus(1'b1, 1'b1);
        bus(1'b0, 1'b1);
        bus(1'b1, 1'b1);
        bus(1'b0, 1'b0);
        bus(1'b1, 1'b1);
    endtask

    task automatic test_short_transfer();
        run_transfer(2);
    endtask

    task automatic test_image_fill();
        for (int i = 0; i < IMAGE_DEPTH; i++)
            send_item(OP_LOAD_BYTE, 1'($urandom_range(1)), 1'($urandom_range(1)), IDX_W'(i),
                      BYTE_W'($urandom_range(255)));
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (2) run_transfer($urandom_range(1, 4));
        hold_until_drained();
        no_idle = 1'b0;
    endtask

    task automatic test_random_traffic();
        int stop_at;
        stop_at = items_sent + 200;
        while (items_sent < stop_at)
        begin
            case ($urandom_range(9))
                0: noise_burst();
                1:
                begin
                    cut_left = $urandom_range(5, 200);
                    run_transfer($urandom_range(1, 4));
                    cut_left = -1;
                    noise_burst();
                end
                default: run_transfer($urandom_range(1, 3));
            endcase
        end
    endtask

    task automatic report_field(input string name, input int want, input int got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
    endtask

    always @(posedge clk)
    begin
        resp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_responses.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with none expected, actual pull %0d status %0d sent %0d",
                         $time, sda_pull_low, status, bytes_sent);
            end
            else
            begin
                want = pending_responses.pop_front();
                responses_checked++;
                if (sda_pull_low !== want.drive_low)
                    report_field("sda_pull_low", int'(want.drive_low), int'(sda_pull_low));
                if (status !== want.status)
                    report_field("status", int'(want.status), int'(status));
                if (bytes_sent !== want.read_index)
                    report_field("bytes_sent", int'(want.read_index), int'(bytes_sent));
            end
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_load_extremes();
        test_bad_start();
        test_short_transfer();
        hold_until_drained();
        test_image_fill();
        hold_until_drained();
        test_back_to_back();
        test_random_traffic();
        hold_until_drained();
        repeat (5) @(posedge clk);
        $display("Covered %0d transfers in, %0d results checked, %0d mismatches.",
                 items_sent, responses_checked, mismatches);
        $display("Reads ended by NACK: %0d, bad starts: %0d, with stalled and gapless traffic.",
                 nack_ends, bad_starts);
        if (mismatches == 0)
            $display("** i2c_slave_eeprom_image_server: PASSED **");
        else
            $display("** i2c_slave_eeprom_image_server: FAILED **");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d results outstanding.", pending_responses.size());
        $display("** i2c_slave_eeprom_image_server: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
sv/i2cee_pkg.sv
sv/i2cee_image_ram.sv
sv/i2cee_bus_fsm.sv
sv/i2c_slave_eeprom_image_server.sv
verif/tb_i2c_slave_eeprom_image_server.sv
